>>> sv/char_lcd_dirty_row_refresher_defines.svh
// assertion macros shared by the checker file
`ifndef CHAR_LCD_DIRTY_ROW_REFRESHER_DEFINES_SVH
`define CHAR_LCD_DIRTY_ROW_REFRESHER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define CLDR_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define CLDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks across reset
`define CLDR_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cldr_pkg.sv
package cldr_pkg;

  localparam int ROWS    = 4;
  localparam int COLS    = 20;
  localparam int ROW_W   = 2;
  localparam int COL_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int DEPTH   = ROWS * COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  // item queue depth, power of two so the pointers wrap by themselves
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic {
    CMD_CURSOR = 1'b0,
    CMD_CHAR   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    RS_IDLE   = 2'd0,
    RS_CURSOR = 2'd1,
    RS_CHAR   = 2'd2
  } refresh_state_t;

  typedef enum logic [1:0] {
    BK_READY = 2'd0,
    BK_WCMP  = 2'd1,
    BK_RCHAR = 2'd2
  } back_state_t;

  typedef struct packed {
    logic              is_write;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] chr;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } item_q_t;

endpackage

>>> sv/char_lcd_dirty_row_refresher.sv
// a cursor word is registered from its queued tick; a character word also waits on
//   the buffer read; both wait longer behind queued words or an unpopped result
// the back sequencer and its shadow buffer pace the words: after an in-range
//   write or a character tick, no word is taken until BK_WCMP or BK_RCHAR ends
// the two-word input queue keeps taking words while a result waits, until it fills
// reset: synchronous active-low rst_n; clears queues, dirty marks, refresh
//   machine and the per-entry valid bits, so the buffer reads as all zero
module char_lcd_dirty_row_refresher (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word channel
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_kind,
  input  logic [cldr_pkg::ROW_W-1:0]  in_row_index,
  input  logic [cldr_pkg::COL_W-1:0]  in_column_index,
  input  logic [cldr_pkg::CHAR_W-1:0] in_char_code,
  // result word channel
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_command,
  output logic [cldr_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [cldr_pkg::CHAR_W-1:0] out_char
);
  import cldr_pkg::*;

  // classified words waiting for the back end
  item_q_t q;
  logic    deq;

  // front: takes words, checks range, computes the buffer address
  cldr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_char_code    (in_char_code),
    .deq             (deq),
    .q               (q)
  );

  // back: shadow buffer compare and store, dirty marks, refresh machine
  // and the result register
  cldr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q              (q),
    .deq            (deq),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_command    (out_command),
    .out_cursor_row (out_cursor_row),
    .out_char       (out_char)
  );

endmodule

>>> sv/cldr_front.sv
module cldr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_kind,
  input  logic [cldr_pkg::ROW_W-1:0] in_row_index,
  input  logic [cldr_pkg::COL_W-1:0] in_column_index,
  input  logic [cldr_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       deq,
  output cldr_pkg::item_q_t          q
);
  import cldr_pkg::*;

  item_t             ents_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             cls;
  logic              enq;
  logic              do_deq;

  // classify the word on the way in
  always_comb begin
    cls.is_write = (in_kind == KIND_WRITE);
    cls.in_range = (int'(in_row_index) < ROWS) && (int'(in_column_index) < COLS);
    cls.addr     = ADDR_W'(int'(in_row_index) * COLS + int'(in_column_index));
    cls.row      = in_row_index;
    cls.chr      = in_char_code;
  end

  assign in_full = (cnt_r == QCNT_W'(Q_DEPTH));
  assign enq     = in_push && !in_full;
  assign do_deq  = deq && (cnt_r != '0);

  assign q.avail = (cnt_r != '0);
  assign q.item  = ents_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq && !do_deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!enq && do_deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      ents_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> sv/cldr_back.sv
module cldr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cldr_pkg::item_q_t           q,
  output logic                        deq,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_command,
  output logic [cldr_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [cldr_pkg::CHAR_W-1:0] out_char
);
  import cldr_pkg::*;

  back_state_t       bk_r, bk_nxt;
  refresh_state_t    rs_r, rs_nxt;
  logic [ROW_W-1:0]  rrow_r, rrow_nxt;
  logic [COL_W-1:0]  rcol_r, rcol_nxt;
  logic              dirty_r [ROWS];
  logic              dirty_nxt [ROWS];
  logic [ADDR_W-1:0] hold_addr_r, hold_addr_nxt;
  logic [ROW_W-1:0]  hold_row_r, hold_row_nxt;
  logic [CHAR_W-1:0] hold_chr_r, hold_chr_nxt;

  logic              ov_r, ov_nxt;
  logic              ocmd_r, ocmd_nxt;
  logic [ROW_W-1:0]  orow_r, orow_nxt;
  logic [CHAR_W-1:0] ochr_r, ochr_nxt;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic              valid_r [DEPTH];
  logic [CHAR_W-1:0] rdata_r;
  logic              rd_valid_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic              slot_free;
  logic [CHAR_W-1:0] old_chr;
  logic              found;

  assign slot_free      = !ov_r || out_pop;
  assign old_chr        = rd_valid_r ? rdata_r : '0;
  assign out_empty      = !ov_r;
  assign out_command    = ocmd_r;
  assign out_cursor_row = orow_r;
  assign out_char       = ochr_r;

  always_comb begin
    bk_nxt        = bk_r;
    rs_nxt        = rs_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    dirty_nxt     = dirty_r;
    hold_addr_nxt = hold_addr_r;
    hold_row_nxt  = hold_row_r;
    hold_chr_nxt  = hold_chr_r;
    ov_nxt        = ov_r && !out_pop;
    ocmd_nxt      = ocmd_r;
    orow_nxt      = orow_r;
    ochr_nxt      = ochr_r;
    deq           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(int'(rrow_r) * COLS + int'(rcol_r));
    wr_en         = 1'b0;
    found         = 1'b0;

    unique case (bk_r)
      BK_READY: begin
        if (q.avail) begin
          if (q.item.is_write) begin
            deq = 1'b1;
            if (q.item.in_range) begin
              rd_en         = 1'b1;
              rd_addr       = q.item.addr;
              hold_addr_nxt = q.item.addr;
              hold_row_nxt  = q.item.row;
              hold_chr_nxt  = q.item.chr;
              bk_nxt        = BK_WCMP;
            end
          end else begin
            unique case (rs_r)
              RS_IDLE: begin
                deq = 1'b1;
                for (int i = 0; i < ROWS; i++) begin
                  if (dirty_r[i] && !found) begin
                    found    = 1'b1;
                    rrow_nxt = ROW_W'(i);
                    rcol_nxt = '0;
                    rs_nxt   = RS_CURSOR;
                  end
                end
              end
              RS_CURSOR: begin
                if (slot_free) begin
                  deq      = 1'b1;
                  ov_nxt   = 1'b1;
                  ocmd_nxt = CMD_CURSOR;
                  orow_nxt = rrow_r;
                  ochr_nxt = '0;
                  rs_nxt   = RS_CHAR;
                end
              end
              RS_CHAR: begin
                deq    = 1'b1;
                rd_en  = 1'b1;
                bk_nxt = BK_RCHAR;
              end
              default: begin
                deq    = 1'b1;
                rs_nxt = RS_IDLE;
              end
            endcase
          end
        end
      end
      BK_WCMP: begin
        if (old_chr != hold_chr_r) begin
          wr_en                 = 1'b1;
          dirty_nxt[hold_row_r] = 1'b1;
        end
        bk_nxt = BK_READY;
      end
      BK_RCHAR: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ocmd_nxt = CMD_CHAR;
          orow_nxt = '0;
          ochr_nxt = old_chr;
          rcol_nxt = rcol_r + 1'b1;
          if (int'(rcol_r) + 1 >= COLS) begin
            dirty_nxt[rrow_r] = 1'b0;
            rs_nxt            = RS_IDLE;
          end
          bk_nxt = BK_READY;
        end
      end
      default: bk_nxt = BK_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_r   <= BK_READY;
      rs_r   <= RS_IDLE;
      rrow_r <= '0;
      rcol_r <= '0;
      ov_r   <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        dirty_r[i] <= 1'b0;
      end
    end else begin
      bk_r    <= bk_nxt;
      rs_r    <= rs_nxt;
      rrow_r  <= rrow_nxt;
      rcol_r  <= rcol_nxt;
      ov_r    <= ov_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_addr_r <= hold_addr_nxt;
    hold_row_r  <= hold_row_nxt;
    hold_chr_r  <= hold_chr_nxt;
    ocmd_r      <= ocmd_nxt;
    orow_r      <= orow_nxt;
    ochr_r      <= ochr_nxt;
  end

  // shadow buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[hold_addr_r] <= hold_chr_r;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      valid_r[hold_addr_r] <= 1'b1;
    end
  end

endmodule

>>> sv/cldr_checker.sv
`include "char_lcd_dirty_row_refresher_defines.svh"

module cldr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic                        out_command,
  input logic [cldr_pkg::ROW_W-1:0]  out_cursor_row,
  input logic [cldr_pkg::CHAR_W-1:0] out_char
);
  import cldr_pkg::*;

  logic [CHAR_W+ROW_W:0] out_word;
  logic                  stall;
  logic                  is_cursor;
  logic                  is_char;

  assign out_word  = {out_command, out_cursor_row, out_char};
  assign stall     = !out_empty && !out_pop;
  assign is_cursor = !out_empty && out_command == CMD_CURSOR;
  assign is_char   = !out_empty && out_command == CMD_CHAR;

  `CLDR_ASSERT_NXT(a_hold, stall, !out_empty && $stable(out_word), "stalled result changed")
  `CLDR_ASSERT_IMM(a_cursor_zero, is_cursor, out_char == '0, "cursor word carries a character")
  `CLDR_ASSERT_IMM(a_char_row_zero, is_char, out_cursor_row == '0, "character word carries a row")
  `CLDR_ASSERT_RST(a_reset, !rst_n, out_empty && !in_full, "queues not empty after reset")

endmodule

bind char_lcd_dirty_row_refresher cldr_checker u_cldr_checker (.*);
